>>> hdl/arfima_pkg.sv
// Package for the ARFIMA impulse response generator.
// Holds fixed field widths, register codes and the rounding and clipping helpers.
// No dependencies.
package arfima_pkg;

    localparam int WEIGHT_W   = 32;
    localparam int FRAC_BITS  = 24;
    localparam int COEF_W     = 18;
    localparam int DIFF_W     = 17;
    localparam int ORDER_W    = 2;
    localparam int LEN_W      = 7;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Orders above these limits are clamped.
    localparam logic [ORDER_W-1:0] MAX_AR = 2'd2;
    localparam logic [ORDER_W-1:0] MAX_MA = 2'd2;

    // Restoring division of a 33-bit dividend, one quotient bit per cycle.
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 32'sd1 <<< FRAC_BITS;

    localparam logic [2:0] REG_AR_ORDER   = 3'd0;
    localparam logic [2:0] REG_MA_ORDER   = 3'd1;
    localparam logic [2:0] REG_AR_FIRST   = 3'd2;
    localparam logic [2:0] REG_AR_SECOND  = 3'd3;
    localparam logic [2:0] REG_MA_FIRST   = 3'd4;
    localparam logic [2:0] REG_MA_SECOND  = 3'd5;
    localparam logic [2:0] REG_FRAC_DIFF  = 3'd6;
    localparam logic [2:0] REG_RESP_LEN   = 3'd7;

    typedef struct packed {
        logic [WEIGHT_W-1:0] value;
        logic                clipped;
    } sat_result_t;

    // Round half up, then shift right arithmetically by s bits.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                        input int unsigned s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (x + half) >>> s;
    endfunction

    // Clip to the signed 32-bit range and report whether clipping happened.
    function automatic sat_result_t saturate_w(input logic signed [63:0] x);
        sat_result_t r;
        if (x > 64'sd2147483647) begin
            r.value   = 32'h7FFF_FFFF;
            r.clipped = 1'b1;
        end else if (x < -64'sd2147483648) begin
            r.value   = 32'h8000_0000;
            r.clipped = 1'b1;
        end else begin
            r.value   = x[WEIGHT_W-1:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hdl/arfima_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module arfima_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/arfima_impulse_response_generator_top.sv
// Top level of the ARFIMA impulse response generator.
// Depends on arfima_pkg and on arfima_ram for the two weight memories.
//
// Usage: each request on the s_ channel (valid/ready) asks for the next sample h[i]
// of the impulse response of an ARFIMA(p,d,q) model; s_restart set to one starts
// over at index 0. The index counts up and wraps after response_length samples.
// Every request gives exactly one result on the m_ channel: the index, the value
// in signed Q8.24, a last-sample flag and a flag that tells whether any value of
// this step was clipped.
// A request first computes weight i of the ARMA sequence psi and of the
// fractional-difference sequence b and writes both into their memories; the
// result is then the convolution of the two stored sequences.
// The reciprocal divider, followed by the ratio and weight multiplies, sets the
// latency for smaller indexes; for larger indexes the convolution over the
// memories, one multiply-accumulate per cycle, sets it. One request is in work
// at a time, and the next is taken only after the result is registered.
// The result sits in an output register, so a new request is taken while the
// receiver stalls; the block then holds the next result until the register frees.
// Reset sets the index to 0 and the registers to their defaults (length 64).
// The weight memories are not cleared: an entry is always written before read.
// Configuration goes through an APB port, registers at byte address 4*n.
module arfima_impulse_response_generator_top #(
    parameter int MAX_LEN = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [$clog2(MAX_LEN)-1:0]          m_sample_index,
    output logic signed [arfima_pkg::WEIGHT_W-1:0] m_response_value,
    output logic                                m_last_sample,
    output logic                                m_saturated,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [arfima_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [arfima_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [arfima_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready
);

    import arfima_pkg::*;

    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int FACT_W     = IDX_W + DIFF_W + 1;
    localparam int RPROD_W    = FACT_W + WEIGHT_W + 1;
    localparam int PSI_PROD_W = WEIGHT_W + COEF_W;
    localparam int PSI_ACC_W  = PSI_PROD_W + 2;
    localparam int WPROD_W    = 2 * WEIGHT_W;
    localparam int CONV_W     = WPROD_W - FRAC_BITS + IDX_W + 2;

    // Sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_PSI_MUL0  = 4'd1;
    localparam logic [3:0] ST_PSI_MUL1  = 4'd2;
    localparam logic [3:0] ST_PSI_ADD   = 4'd3;
    localparam logic [3:0] ST_PSI_RND   = 4'd4;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd5;
    localparam logic [3:0] ST_RATIO_MUL = 4'd6;
    localparam logic [3:0] ST_RATIO_RND = 4'd7;
    localparam logic [3:0] ST_B_MUL     = 4'd8;
    localparam logic [3:0] ST_B_RND     = 4'd9;
    localparam logic [3:0] ST_CONV_WAIT = 4'd10;
    localparam logic [3:0] ST_OUT       = 4'd11;

    // Configuration registers
    logic [ORDER_W-1:0]       ar_order_reg;
    logic [ORDER_W-1:0]       ma_order_reg;
    logic signed [COEF_W-1:0] ar_coef_first_reg;
    logic signed [COEF_W-1:0] ar_coef_second_reg;
    logic signed [COEF_W-1:0] ma_coef_first_reg;
    logic signed [COEF_W-1:0] ma_coef_second_reg;
    logic signed [DIFF_W-1:0] frac_diff_reg;
    logic [LEN_W-1:0]         response_length_reg;

    // Control state
    logic [3:0]           state_reg, state_next;
    logic [IDX_W-1:0]     next_index_reg;
    logic [IDX_W-1:0]     i_reg;
    logic                 last_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 conv_issue_reg;
    logic                 conv_v1_reg;
    logic                 conv_v2_reg;
    logic                 m_valid_reg;

    // Datapath registers
    logic [IDX_W-1:0]              div_rem_reg;
    logic [DIV_STEPS-1:0]          div_q_reg;
    logic signed [PSI_PROD_W-1:0]  psi_prod_reg;
    logic signed [PSI_ACC_W-1:0]   psi_acc_reg;
    logic signed [WEIGHT_W-1:0]    psi_new_reg;
    logic                          psi_sat_reg;
    logic signed [WEIGHT_W-1:0]    psi1_reg;
    logic signed [WEIGHT_W-1:0]    psi2_reg;
    logic signed [RPROD_W-1:0]     ratio_prod_reg;
    logic signed [WEIGHT_W-1:0]    ratio_reg;
    logic signed [WPROD_W-1:0]     b_prod_reg;
    logic signed [WEIGHT_W-1:0]    b_new_reg;
    logic                          b_sat_reg;
    logic signed [WEIGHT_W-1:0]    b1_reg;
    logic [IDX_W-1:0]              conv_j_reg;
    logic signed [WPROD_W-1:0]     conv_prod_reg;
    logic signed [CONV_W-1:0]      conv_acc_reg;
    logic [IDX_W-1:0]              m_sample_index_reg;
    logic signed [WEIGHT_W-1:0]    m_response_value_reg;
    logic                          m_last_sample_reg;
    logic                          m_saturated_reg;

    // Combinational signals
    logic                         in_accept;
    logic                         out_free;
    logic                         cfg_write;
    logic [ORDER_W-1:0]           p_eff;
    logic [ORDER_W-1:0]           q_eff;
    logic [IDX_W-1:0]             len_m1;
    logic [IDX_W-1:0]             i_sel;
    logic signed [COEF_W-1:0]     ma_sel;
    logic signed [COEF_W-1:0]     ar0_eff;
    logic signed [COEF_W-1:0]     ar1_eff;
    logic signed [WEIGHT_W-1:0]   psi_mul_a;
    logic signed [COEF_W-1:0]     psi_mul_b;
    sat_result_t                  psi_sat_c;
    logic signed [WEIGHT_W-1:0]   psi_new_c;
    sat_result_t                  b_sat_c;
    logic signed [WEIGHT_W-1:0]   b_new_c;
    logic [IDX_W:0]               div_trial;
    logic                         div_ge;
    logic [IDX_W-1:0]             i_m1;
    logic signed [FACT_W-1:0]     factor_c;
    logic [IDX_W-1:0]             b_rd_addr;
    logic signed [WEIGHT_W-1:0]   psi_rd;
    logic signed [WEIGHT_W-1:0]   b_rd;
    logic                         conv_done;
    logic signed [CONV_W-1:0]     h_sum;
    sat_result_t                  h_sat_c;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Effective orders and last index of the response.
    assign p_eff = (ar_order_reg > MAX_AR) ? MAX_AR : ar_order_reg;
    assign q_eff = (ma_order_reg > MAX_MA) ? MAX_MA : ma_order_reg;

    always_comb begin
        if (response_length_reg == '0) begin
            len_m1 = '0;
        end else if (int'(response_length_reg) > MAX_LEN) begin
            len_m1 = IDX_W'(MAX_LEN - 1);
        end else begin
            len_m1 = IDX_W'(response_length_reg - LEN_W'(1));
        end
    end

    // Index of the sample this request produces. A stale index beyond the
    // length falls back to the start of the response.
    always_comb begin
        if (s_restart || (next_index_reg > len_m1)) begin
            i_sel = '0;
        end else begin
            i_sel = next_index_reg;
        end
    end

    // The MA term enters psi[i] only for i from 1 to q.
    always_comb begin
        if (({1'b0, i_sel} == (IDX_W + 1)'(1)) && (q_eff >= 2'd1)) begin
            ma_sel = ma_coef_first_reg;
        end else if (({1'b0, i_sel} == (IDX_W + 1)'(2)) && (q_eff >= 2'd2)) begin
            ma_sel = ma_coef_second_reg;
        end else begin
            ma_sel = '0;
        end
    end

    // AR terms are gated by the order and by how many earlier weights exist.
    assign ar0_eff = ((p_eff >= 2'd1) && (i_reg != '0)) ? ar_coef_first_reg : '0;
    assign ar1_eff = ((p_eff >= 2'd2) && ({1'b0, i_reg} >= (IDX_W + 1)'(2)))
                     ? ar_coef_second_reg : '0;

    // One multiplier serves both AR taps, one per cycle.
    assign psi_mul_a = (state_reg == ST_PSI_MUL0) ? psi1_reg : psi2_reg;
    assign psi_mul_b = (state_reg == ST_PSI_MUL0) ? ar0_eff : ar1_eff;

    assign psi_sat_c = saturate_w(round_shift(64'(psi_acc_reg), 16));
    assign psi_new_c = (i_reg == '0) ? WEIGHT_ONE : $signed(psi_sat_c.value);

    assign b_sat_c = saturate_w(round_shift(64'(b_prod_reg), 30));
    assign b_new_c = (i_reg == '0) ? WEIGHT_ONE : $signed(b_sat_c.value);

    // Restoring divider for the reciprocal (2^32 + floor(i/2)) / i.
    assign div_trial = {div_rem_reg, div_q_reg[DIV_STEPS-1]};
    assign div_ge    = (div_trial >= {1'b0, i_reg});

    // Numerator of the weight ratio: d + (i - 1), in Q16.
    assign i_m1     = i_reg - IDX_W'(1);
    assign factor_c = FACT_W'(frac_diff_reg)
                    + $signed({{(FACT_W - IDX_W - 16){1'b0}}, i_m1, 16'b0});

    // Convolution reads psi[j] and b[i-j] for j from 1 to i-1. The end terms
    // psi[0]*b[i] and psi[i]*b[0] reduce to b[i] and psi[i], since both
    // sequences start at exactly one.
    assign b_rd_addr = i_reg - conv_j_reg;
    assign conv_done = !conv_issue_reg && !conv_v1_reg && !conv_v2_reg;

    always_comb begin
        if (i_reg == '0) begin
            h_sum = CONV_W'(WEIGHT_ONE);
        end else begin
            h_sum = conv_acc_reg + CONV_W'(psi_new_reg) + CONV_W'(b_new_reg);
        end
    end

    assign h_sat_c = saturate_w(64'(h_sum));

    arfima_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_LEN)
    ) u_psi_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_PSI_RND),
        .wr_addr (i_reg),
        .wr_data (psi_new_c),
        .rd_addr (conv_j_reg),
        .rd_data (psi_rd)
    );

    arfima_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_LEN)
    ) u_b_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_B_RND),
        .wr_addr (i_reg),
        .wr_data (b_new_c),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd)
    );

    // Sequencer. The divider and the convolution start at the request and run
    // alongside the psi update; the weight update waits for the divider and
    // the result waits for the convolution.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_PSI_MUL0;
                end
            end
            ST_PSI_MUL0:  state_next = ST_PSI_MUL1;
            ST_PSI_MUL1:  state_next = ST_PSI_ADD;
            ST_PSI_ADD:   state_next = ST_PSI_RND;
            ST_PSI_RND:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_RATIO_MUL;
                end
            end
            ST_RATIO_MUL: state_next = ST_RATIO_RND;
            ST_RATIO_RND: state_next = ST_B_MUL;
            ST_B_MUL:     state_next = ST_B_RND;
            ST_B_RND:     state_next = ST_CONV_WAIT;
            ST_CONV_WAIT: begin
                if (conv_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            next_index_reg      <= '0;
            div_cnt_reg         <= '0;
            conv_issue_reg      <= 1'b0;
            conv_v1_reg         <= 1'b0;
            conv_v2_reg         <= 1'b0;
            m_valid_reg         <= 1'b0;
            ar_order_reg        <= '0;
            ma_order_reg        <= '0;
            ar_coef_first_reg   <= '0;
            ar_coef_second_reg  <= '0;
            ma_coef_first_reg   <= '0;
            ma_coef_second_reg  <= '0;
            frac_diff_reg       <= '0;
            response_length_reg <= LEN_W'(64);
        end else begin
            state_reg <= state_next;

            if (cfg_write) begin
                case (paddr[4:2])
                    REG_AR_ORDER:  ar_order_reg        <= pwdata[ORDER_W-1:0];
                    REG_MA_ORDER:  ma_order_reg        <= pwdata[ORDER_W-1:0];
                    REG_AR_FIRST:  ar_coef_first_reg   <= $signed(pwdata[COEF_W-1:0]);
                    REG_AR_SECOND: ar_coef_second_reg  <= $signed(pwdata[COEF_W-1:0]);
                    REG_MA_FIRST:  ma_coef_first_reg   <= $signed(pwdata[COEF_W-1:0]);
                    REG_MA_SECOND: ma_coef_second_reg  <= $signed(pwdata[COEF_W-1:0]);
                    REG_FRAC_DIFF: frac_diff_reg       <= $signed(pwdata[DIFF_W-1:0]);
                    REG_RESP_LEN:  response_length_reg <= pwdata[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_accept) begin
                div_cnt_reg    <= DIV_CNT_W'(DIV_STEPS);
                conv_issue_reg <= ({1'b0, i_sel} >= (IDX_W + 1)'(2));
            end else begin
                if (div_cnt_reg != '0) begin
                    div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                end
                if (conv_issue_reg && (conv_j_reg == i_m1)) begin
                    conv_issue_reg <= 1'b0;
                end
            end
            conv_v1_reg <= conv_issue_reg;
            conv_v2_reg <= conv_v1_reg;

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg    <= 1'b1;
                next_index_reg <= last_reg ? '0 : i_reg + IDX_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            i_reg        <= i_sel;
            last_reg     <= (i_sel == len_m1);
            div_rem_reg  <= '0;
            div_q_reg    <= {1'b1, 32'(i_sel >> 1)};
            psi_acc_reg  <= PSI_ACC_W'(ma_sel) <<< FRAC_BITS;
            conv_j_reg   <= IDX_W'(1);
            conv_acc_reg <= '0;
        end else begin
            if (div_cnt_reg != '0) begin
                div_rem_reg <= div_ge ? IDX_W'(div_trial - {1'b0, i_reg})
                                      : IDX_W'(div_trial);
                div_q_reg   <= {div_q_reg[DIV_STEPS-2:0], div_ge};
            end
            if (conv_issue_reg) begin
                conv_j_reg <= conv_j_reg + IDX_W'(1);
            end
            if (conv_v2_reg) begin
                conv_acc_reg <= conv_acc_reg
                              + CONV_W'(round_shift(64'(conv_prod_reg), FRAC_BITS));
            end
        end

        conv_prod_reg <= psi_rd * b_rd;

        case (state_reg)
            ST_PSI_MUL0: begin
                psi_prod_reg <= psi_mul_a * psi_mul_b;
            end
            ST_PSI_MUL1: begin
                psi_acc_reg  <= psi_acc_reg + PSI_ACC_W'(psi_prod_reg);
                psi_prod_reg <= psi_mul_a * psi_mul_b;
            end
            ST_PSI_ADD: begin
                psi_acc_reg <= psi_acc_reg + PSI_ACC_W'(psi_prod_reg);
            end
            ST_PSI_RND: begin
                psi_new_reg <= psi_new_c;
                psi_sat_reg <= (i_reg != '0) && psi_sat_c.clipped;
            end
            ST_RATIO_MUL: begin
                ratio_prod_reg <= factor_c * $signed({1'b0, div_q_reg[WEIGHT_W-1:0]});
            end
            ST_RATIO_RND: begin
                // For i = 1 the reciprocal is exactly 2^32 and the ratio is d in Q30.
                if (i_reg == IDX_W'(1)) begin
                    ratio_reg <= WEIGHT_W'(frac_diff_reg) <<< 14;
                end else begin
                    ratio_reg <= WEIGHT_W'(round_shift(64'(ratio_prod_reg), 18));
                end
            end
            ST_B_MUL: begin
                b_prod_reg <= b1_reg * ratio_reg;
            end
            ST_B_RND: begin
                b_new_reg <= b_new_c;
                b_sat_reg <= (i_reg != '0) && b_sat_c.clipped;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_sample_index_reg   <= i_reg;
                    m_response_value_reg <= $signed(h_sat_c.value);
                    m_last_sample_reg    <= last_reg;
                    m_saturated_reg      <= psi_sat_reg || b_sat_reg || h_sat_c.clipped;
                    // Keep the latest weights at hand for the next recursion step.
                    // At the start of a response there is no earlier psi, so the
                    // unused second tap sees a clean zero.
                    psi2_reg             <= (i_reg == '0) ? '0 : psi1_reg;
                    psi1_reg             <= psi_new_reg;
                    b1_reg               <= b_new_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_sample_index   = m_sample_index_reg;
    assign m_response_value = m_response_value_reg;
    assign m_last_sample    = m_last_sample_reg;
    assign m_saturated      = m_saturated_reg;

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            REG_AR_ORDER:  prdata = APB_DATA_W'(ar_order_reg);
            REG_MA_ORDER:  prdata = APB_DATA_W'(ma_order_reg);
            REG_AR_FIRST:  prdata = APB_DATA_W'(unsigned'(ar_coef_first_reg));
            REG_AR_SECOND: prdata = APB_DATA_W'(unsigned'(ar_coef_second_reg));
            REG_MA_FIRST:  prdata = APB_DATA_W'(unsigned'(ma_coef_first_reg));
            REG_MA_SECOND: prdata = APB_DATA_W'(unsigned'(ma_coef_second_reg));
            REG_FRAC_DIFF: prdata = APB_DATA_W'(unsigned'(frac_diff_reg));
            REG_RESP_LEN:  prdata = APB_DATA_W'(response_length_reg);
            default:       prdata = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    // A request is only taken once the divider and the convolution have drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> (div_cnt_reg == '0) && !conv_issue_reg && !conv_v1_reg && !conv_v2_reg)
        else $error("request taken while the previous one is still in work");

    // The ratio multiply must see a finished quotient.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RATIO_MUL) |-> (div_cnt_reg == '0))
        else $error("ratio computed from an unfinished reciprocal");

    // The convolution never reads the entry that is being written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        conv_issue_reg |-> (conv_j_reg != i_reg) && (b_rd_addr != i_reg))
        else $error("convolution read overlaps the weight write");

    // Finishing a request always presents a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && out_free |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("finished result not presented");

    // The first sample of a response is exactly one and never clipped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_sample_index_reg == '0)
            |-> (m_response_value_reg == WEIGHT_ONE) && !m_saturated_reg)
        else $error("sample zero is not one");
`endif

endmodule
